[design/e2r_pkg.sv]
// ============================================================================
// e2r_pkg
// shared constants, types and helpers for the euler to rotation matrix core
// ============================================================================
package e2r_pkg;

    localparam int IQ              = 30;
    localparam int OUT_FRAC_BITS   = 14;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int ANGLE_W         = 16;
    localparam int SIN_STEPS       = 6;
    localparam int COS_STEPS       = 7;
    localparam int N_STEPS         = 7;

    // pi/180 in Q36
    localparam logic [30:0] DEG2RAD_Q36 = 31'd1199381129;

    // magnitude of a Q30 value, 0..1.0 needs 31 bits
    typedef logic [30:0]        t_mag;
    typedef logic signed [31:0] t_q30;

    // fold flags of one angle on its way through the series
    typedef struct packed {
        logic sneg;
        logic cneg;
        logic swap;
    } t_fold;

    function automatic logic [7:0] sin_div(input int i);
        logic [7:0] d;
        begin
            unique case (i)
                0: d = 8'd156;
                1: d = 8'd110;
                2: d = 8'd72;
                3: d = 8'd42;
                4: d = 8'd20;
                default: d = 8'd6;
            endcase
            return d;
        end
    endfunction

    function automatic logic [7:0] cos_div(input int i);
        logic [7:0] d;
        begin
            unique case (i)
                0: d = 8'd182;
                1: d = 8'd132;
                2: d = 8'd90;
                3: d = 8'd56;
                4: d = 8'd30;
                5: d = 8'd12;
                default: d = 8'd2;
            endcase
            return d;
        end
    endfunction

    // shift of the reciprocal for an exact floor(n / d), n below 2^IQ
    function automatic int recip_shift(input logic [7:0] d);
        begin
            return IQ + $clog2(d);
        end
    endfunction

    // reciprocal multiplier, ceil(2^shift / d), always below 2^31
    function automatic logic [30:0] recip_mul(input logic [7:0] d);
        logic [63:0] num;
        begin
            num = (64'd1 << recip_shift(d)) + 64'(d) - 64'd1;
            return 31'(num / 64'(d));
        end
    endfunction

    // Q30 product rounded half away from zero
    function automatic t_q30 mulq(input t_q30 a, input t_q30 b);
        logic        neg;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] p;
        begin
            neg = a[31] ^ b[31];
            ma  = a[31] ? 32'(-a) : 32'(a);
            mb  = b[31] ? 32'(-b) : 32'(b);
            p   = ((ma * mb) + (64'd1 << (IQ - 1))) >> IQ;
            return neg ? -t_q30'(p[31:0]) : t_q30'(p[31:0]);
        end
    endfunction

    // Q30 to output fraction, rounded half away from zero, saturated
    function automatic logic [OUT_FRAC_BITS+1:0] to_out(input logic signed [33:0] v);
        logic        neg;
        logic [33:0] m;
        logic [33:0] lim;
        logic [33:0] r;
        begin
            neg = v[33];
            m   = neg ? 34'(-v) : 34'(v);
            m   = (m + (34'd1 << (IQ - OUT_FRAC_BITS - 1))) >> (IQ - OUT_FRAC_BITS);
            lim = 34'd1 << OUT_FRAC_BITS;
            if (m > lim) begin
                m = lim;
            end
            r = neg ? -m : m;
            return r[OUT_FRAC_BITS+1:0];
        end
    endfunction

endpackage

[design/e2r_sincos.sv]
// ============================================================================
// e2r_sincos
// pipelined fixed-point sine and cosine of one angle in degrees
// ============================================================================
module e2r_sincos
    import e2r_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [ANGLE_W-1:0] i_deg,
    output t_q30                      o_sin,
    output t_q30                      o_cos
);

    localparam int   LIMIT   = 180 << ANGLE_FRAC_BITS;
    localparam int   QUARTER = 90 << ANGLE_FRAC_BITS;
    localparam int   EIGHTH  = 45 << ANGLE_FRAC_BITS;
    localparam t_mag ONE_Q   = 31'd1 << IQ;

    // stage 0: clamp and fold
    t_fold       n_f0;
    logic [15:0] n_a0;
    t_fold       r_f0;
    logic [15:0] r_a0;

    always_comb begin
        logic signed [16:0] d;
        logic [16:0]        a;
        d = 17'(i_deg);
        if (d > 17'sd0 + 17'(LIMIT)) begin
            d = 17'(LIMIT);
        end
        if (d < -17'(LIMIT)) begin
            d = -17'(LIMIT);
        end
        n_f0.sneg = d[16];
        n_f0.cneg = 1'b0;
        n_f0.swap = 1'b0;
        a = d[16] ? 17'(-d) : 17'(d);
        if (a > 17'(QUARTER)) begin
            a = 17'(2 * QUARTER) - a;
            n_f0.cneg = 1'b1;
        end
        if (a > 17'(EIGHTH)) begin
            a = 17'(QUARTER) - a;
            n_f0.swap = 1'b1;
        end
        n_a0 = a[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f0 <= n_f0;
            r_a0 <= n_a0;
        end
    end

    // stage 1: radians in Q30
    t_fold r_f1;
    t_mag  r_x1;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1 <= r_f0;
            r_x1 <= 31'(((48'(r_a0) * 48'(DEG2RAD_Q36))
                    + (48'd1 << (5 + ANGLE_FRAC_BITS))) >> (6 + ANGLE_FRAC_BITS));
        end
    end

    // stage 2: x squared
    t_fold r_f2;
    t_mag  r_x2;
    t_mag  r_xx2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f2  <= r_f1;
            r_x2  <= r_x1;
            r_xx2 <= 31'((62'(r_x1) * 62'(r_x1)) >> IQ);
        end
    end

    // horner steps, sine and cosine side by side, two stages per step:
    // product with x squared, then divide by a reciprocal multiply
    t_fold r_fs [N_STEPS];
    t_mag  r_xs [N_STEPS];
    t_mag  r_qs [N_STEPS];
    t_mag  r_ts [N_STEPS];
    t_mag  r_tc [N_STEPS];

    for (genvar g = 0; g < N_STEPS; g++) begin : g_step
        localparam int         CK = recip_shift(cos_div(g));
        localparam logic [30:0] CM = recip_mul(cos_div(g));

        t_fold       f_in;
        t_mag        x_in;
        t_mag        q_in;
        t_mag        ts_in;
        t_mag        tc_in;
        t_fold       r_fm;
        t_mag        r_xm;
        t_mag        r_qm;
        logic [29:0] r_nc;
        t_mag        n_ts;
        t_mag        n_tc;
        logic [61:0] pc;

        if (g == 0) begin : g_first
            assign f_in  = r_f2;
            assign x_in  = r_x2;
            assign q_in  = r_xx2;
            assign ts_in = ONE_Q;
            assign tc_in = ONE_Q;
        end else begin : g_next
            assign f_in  = r_fs[g-1];
            assign x_in  = r_xs[g-1];
            assign q_in  = r_qs[g-1];
            assign ts_in = r_ts[g-1];
            assign tc_in = r_tc[g-1];
        end

        // first half: product with x squared
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_fm <= f_in;
                r_xm <= x_in;
                r_qm <= q_in;
                r_nc <= 30'((62'(q_in) * 62'(tc_in)) >> IQ);
            end
        end

        // second half: exact floor division by the series constant
        always_comb begin
            pc   = 62'(r_nc) * 62'(CM);
            n_tc = ONE_Q - 31'(pc >> CK);
        end

        if (g < SIN_STEPS) begin : g_sin
            localparam int          SK = recip_shift(sin_div(g));
            localparam logic [30:0] SM = recip_mul(sin_div(g));
            logic [29:0] r_ns;
            logic [61:0] ps;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ns <= 30'((62'(q_in) * 62'(ts_in)) >> IQ);
                end
            end
            always_comb begin
                ps   = 62'(r_ns) * 62'(SM);
                n_ts = ONE_Q - 31'(ps >> SK);
            end
        end else begin : g_hold
            // sine series is shorter, its term just rides along
            t_mag r_th;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_th <= ts_in;
                end
            end
            assign n_ts = r_th;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_fs[g] <= r_fm;
                r_xs[g] <= r_xm;
                r_qs[g] <= r_qm;
                r_ts[g] <= n_ts;
                r_tc[g] <= n_tc;
            end
        end
    end

    // final stage: sine = x * t, unfold
    always_ff @(posedge i_clk) begin
        t_mag sv;
        t_mag cv;
        if (i_en) begin
            sv = 31'((62'(r_xs[N_STEPS-1]) * 62'(r_ts[N_STEPS-1])) >> IQ);
            cv = r_tc[N_STEPS-1];
            if (r_fs[N_STEPS-1].swap) begin
                o_sin <= r_fs[N_STEPS-1].sneg ? -t_q30'({1'b0, cv}) : t_q30'({1'b0, cv});
                o_cos <= r_fs[N_STEPS-1].cneg ? -t_q30'({1'b0, sv}) : t_q30'({1'b0, sv});
            end else begin
                o_sin <= r_fs[N_STEPS-1].sneg ? -t_q30'({1'b0, sv}) : t_q30'({1'b0, sv});
                o_cos <= r_fs[N_STEPS-1].cneg ? -t_q30'({1'b0, cv}) : t_q30'({1'b0, cv});
            end
        end
    end

endmodule

[design/e2r_matrix.sv]
// ============================================================================
// e2r_matrix
// pipelined products and sums forming the nine matrix entries
// ============================================================================
module e2r_matrix
    import e2r_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_en,
    input  t_q30                         i_sp,
    input  t_q30                         i_cp,
    input  t_q30                         i_sr,
    input  t_q30                         i_cr,
    input  t_q30                         i_sy,
    input  t_q30                         i_cy,
    output logic [OUT_FRAC_BITS+1:0]     o_m [9]
);

    // stage a: pairwise products
    t_q30 r_srsp, r_srcp, r_m00, r_m10, r_m21, r_m22, r_sycp, r_sysp, r_cycp, r_cysp;
    t_q30 r_sy, r_cy, r_nsr;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_srsp <= mulq(i_sr, i_sp);
            r_srcp <= mulq(i_sr, i_cp);
            r_m00  <= mulq(i_cy, i_cr);
            r_m10  <= mulq(i_sy, i_cr);
            r_m21  <= mulq(i_cr, i_sp);
            r_m22  <= mulq(i_cr, i_cp);
            r_sycp <= mulq(i_sy, i_cp);
            r_sysp <= mulq(i_sy, i_sp);
            r_cycp <= mulq(i_cy, i_cp);
            r_cysp <= mulq(i_cy, i_sp);
            r_sy   <= i_sy;
            r_cy   <= i_cy;
            r_nsr  <= -i_sr;
        end
    end

    // stage b: triple products and sums
    logic signed [33:0] r_v [9];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0] <= 34'(r_m00);
            r_v[1] <= 34'(mulq(r_cy, r_srsp)) - 34'(r_sycp);
            r_v[2] <= 34'(mulq(r_cy, r_srcp)) + 34'(r_sysp);
            r_v[3] <= 34'(r_m10);
            r_v[4] <= 34'(mulq(r_sy, r_srsp)) + 34'(r_cycp);
            r_v[5] <= 34'(mulq(r_sy, r_srcp)) - 34'(r_cysp);
            r_v[6] <= 34'(r_nsr);
            r_v[7] <= 34'(r_m21);
            r_v[8] <= 34'(r_m22);
        end
    end

    // stage c: round and saturate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                o_m[k] <= to_out(r_v[k]);
            end
        end
    end

endmodule

[design/euler_to_rotation_matrix_core.sv]
// ============================================================================
// euler_to_rotation_matrix_core
// euler angles (pitch, roll, yaw) to a 3x3 rotation matrix, Rz*Ry*Rx
// ============================================================================
// Takes one request per cycle while o_stall is low, each a triple of angles
// in degrees with seven fraction bits, clamped to +-180. The stages are one
// clamp/fold, one radian scale, one square, seven series steps of two stages
// each (product, then reciprocal divide), one sine product and unfold, then
// three matrix stages (products, triple products and sums, rounding and
// saturation). The pipeline holds as a whole while a result waits at the
// output and i_stall is high; valid bits ride with the data so nothing is
// lost or repeated. Outputs are Q1.14, saturated to +-1.0.
module euler_to_rotation_matrix_core
    import e2r_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [ANGLE_W-1:0] i_pitch_deg,
    input  logic signed [ANGLE_W-1:0] i_roll_deg,
    input  logic signed [ANGLE_W-1:0] i_yaw_deg,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [15:0]        o_m00,
    output logic signed [15:0]        o_m01,
    output logic signed [15:0]        o_m02,
    output logic signed [15:0]        o_m10,
    output logic signed [15:0]        o_m11,
    output logic signed [15:0]        o_m12,
    output logic signed [15:0]        o_m20,
    output logic signed [15:0]        o_m21,
    output logic signed [15:0]        o_m22
);

    localparam int LAT = 2 * N_STEPS + 4 + 3;

    // whole pipe advances unless the output holds a request that is stalled
    logic en;
    logic [LAT-1:0] r_vld;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    t_q30 sp, cp, sr, cr, sy, cy;

    e2r_sincos u_pitch (.i_clk, .i_en(en), .i_deg(i_pitch_deg), .o_sin(sp), .o_cos(cp));
    e2r_sincos u_roll  (.i_clk, .i_en(en), .i_deg(i_roll_deg),  .o_sin(sr), .o_cos(cr));
    e2r_sincos u_yaw   (.i_clk, .i_en(en), .i_deg(i_yaw_deg),   .o_sin(sy), .o_cos(cy));

    logic [OUT_FRAC_BITS+1:0] m [9];
    e2r_matrix u_mat (
        .i_clk, .i_en(en),
        .i_sp(sp), .i_cp(cp), .i_sr(sr), .i_cr(cr), .i_sy(sy), .i_cy(cy),
        .o_m(m)
    );

    assign o_m00 = m[0];
    assign o_m01 = m[1];
    assign o_m02 = m[2];
    assign o_m10 = m[3];
    assign o_m11 = m[4];
    assign o_m12 = m[5];
    assign o_m20 = m[6];
    assign o_m21 = m[7];
    assign o_m22 = m[8];

`ifndef SYNTH
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped under stall");
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall without a result");
    a_pipe_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |=> r_vld[0] == $past(i_valid))
        else $error("request lost at entry");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb
// regression for euler_to_rotation_matrix_core
// ============================================================================
// Angle triples are sent over the valid/stall request channel. A behavioral
// predictor in 64-bit integer arithmetic computes the nine Q1.14 entries of
// Rz*Ry*Rx for every accepted request. A checker compares each accepted
// result field by field with the oldest prediction. Both sides idle at random.
// One test holds the result side off for a long stretch so the pipeline
// fills up, and another lets it drain completely.
// ============================================================================
module tb
    import e2r_pkg::*;
();

    localparam int IDLE_PCT   = 14;
    localparam int LATENCY    = 21;
    localparam int CYCLE_CAP  = 200000;
    localparam int N_RANDOM   = 480;
    localparam int ONE_DEG    = 1 << ANGLE_FRAC_BITS;

    typedef logic [8:0][15:0] t_matrix;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic signed [ANGLE_W-1:0] i_pitch_deg;
    logic signed [ANGLE_W-1:0] i_roll_deg;
    logic signed [ANGLE_W-1:0] i_yaw_deg;
    logic                      o_valid;
    logic                      i_stall;
    logic signed [15:0]        o_m00, o_m01, o_m02;
    logic signed [15:0]        o_m10, o_m11, o_m12;
    logic signed [15:0]        o_m20, o_m21, o_m22;

    t_matrix matrix_queue[$];
    int      n_errors    = 0;
    int      n_sent      = 0;
    int      n_checked   = 0;
    int      cycle_count = 0;
    bit      calm        = 0;   // no random idling on either side
    int      hold_cycles = 0;   // requested receiver hold-off length

    euler_to_rotation_matrix_core uut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog on a cycle count
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("euler_to_rotation_matrix_core regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // Q30 product, rounded half away from zero
    function automatic longint q30_product(input longint a, input longint b);
        bit               neg;
        longint unsigned  ma;
        longint unsigned  mb;
        longint unsigned  m;
        begin
            neg = (a < 0) != (b < 0);
            ma  = (a < 0) ? -a : a;
            mb  = (b < 0) ? -b : b;
            m   = (ma * mb + (64'd1 << (IQ - 1))) >> IQ;
            return neg ? -longint'(m) : longint'(m);
        end
    endfunction

    // sine and cosine in Q30 of one clamped angle
    function automatic void angle_trig(input logic signed [15:0] ang,
                                       output longint s, output longint c);
        longint unsigned sdiv[6] = '{156, 110, 72, 42, 20, 6};
        longint unsigned cdiv[7] = '{182, 132, 90, 56, 30, 12, 2};
        longint          deg;
        longint          lim;
        longint unsigned a, x, x2, t, sv, cv, tmp;
        bit              sneg, cneg, swap;
        begin
            deg  = ang;
            lim  = 180 * ONE_DEG;
            cneg = 0;
            swap = 0;
            if (deg > lim)  deg = lim;
            if (deg < -lim) deg = -lim;
            sneg = deg < 0;
            a    = sneg ? -deg : deg;
            // fold into 0..45 degrees
            if (a > 90 * ONE_DEG) begin
                a    = 180 * ONE_DEG - a;
                cneg = 1;
            end
            if (a > 45 * ONE_DEG) begin
                a    = 90 * ONE_DEG - a;
                swap = 1;
            end
            x  = (a * 64'd1199381129 + (64'd1 << (5 + ANGLE_FRAC_BITS)))
                 >> (6 + ANGLE_FRAC_BITS);
            x2 = (x * x) >> IQ;
            t  = 64'd1 << IQ;
            for (int i = 0; i < 6; i++) t = (64'd1 << IQ) - ((x2 * t) >> IQ) / sdiv[i];
            sv = (x * t) >> IQ;
            t  = 64'd1 << IQ;
            for (int i = 0; i < 7; i++) t = (64'd1 << IQ) - ((x2 * t) >> IQ) / cdiv[i];
            cv = t;
            if (swap) begin
                tmp = sv;
                sv  = cv;
                cv  = tmp;
            end
            s = sneg ? -longint'(sv) : longint'(sv);
            c = cneg ? -longint'(cv) : longint'(cv);
        end
    endfunction

    // Q30 to Q1.14, rounded half away from zero and saturated to +-1.0
    function automatic logic [15:0] to_q14(input longint v);
        bit              neg;
        longint unsigned m;
        longint          r;
        begin
            neg = v < 0;
            m   = neg ? -v : v;
            m   = (m + (64'd1 << (IQ - OUT_FRAC_BITS - 1))) >> (IQ - OUT_FRAC_BITS);
            if (m > (64'd1 << OUT_FRAC_BITS)) m = 64'd1 << OUT_FRAC_BITS;
            r = neg ? -longint'(m) : longint'(m);
            return r[15:0];
        end
    endfunction

    function automatic t_matrix rotation_matrix(input logic signed [15:0] pitch,
                                                input logic signed [15:0] roll,
                                                input logic signed [15:0] yaw);
        longint  sp, cp, sr, cr, sy, cy, srsp, srcp;
        t_matrix m;
        begin
            angle_trig(pitch, sp, cp);
            angle_trig(roll, sr, cr);
            angle_trig(yaw, sy, cy);
            srsp = q30_product(sr, sp);
            srcp = q30_product(sr, cp);
            m[0] = to_q14(q30_product(cy, cr));
            m[1] = to_q14(q30_product(cy, srsp) - q30_product(sy, cp));
            m[2] = to_q14(q30_product(cy, srcp) + q30_product(sy, sp));
            m[3] = to_q14(q30_product(sy, cr));
            m[4] = to_q14(q30_product(sy, srsp) + q30_product(cy, cp));
            m[5] = to_q14(q30_product(sy, srcp) - q30_product(cy, sp));
            m[6] = to_q14(-sr);
            m[7] = to_q14(q30_product(cr, sp));
            m[8] = to_q14(q30_product(cr, cp));
            return m;
        end
    endfunction

    // ------------------------------------------------------------------------
    // result side: random stall, plus a counted hold-off on request
    // ------------------------------------------------------------------------
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (hold_cycles != 0 && hold_left == 0) begin
            hold_left   <= hold_cycles;
            hold_cycles <= 0;
            i_stall     <= 1'b1;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            hold_left <= 0;
            i_stall   <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
        end
    end

    // checker: compare every accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_matrix got;
        t_matrix want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_m22, o_m21, o_m20, o_m12, o_m11, o_m10, o_m02, o_m01, o_m00};
            if (matrix_queue.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, got);
                n_errors++;
            end else begin
                want = matrix_queue.pop_front();
                for (int k = 0; k < 9; k++) begin
                    if (got[k] !== want[k]) begin
                        $display("%0t: m%0d%0d expected %0d actual %0d", $time,
                                 k / 3, k % 3, $signed(want[k]), $signed(got[k]));
                        n_errors++;
                    end
                end
                n_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // offer one angle triple and hold it until the block takes it
    task automatic send_angles(input logic signed [15:0] pitch,
                               input logic signed [15:0] roll,
                               input logic signed [15:0] yaw);
        begin
            while (!calm && $urandom_range(99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid     <= 1'b1;
            i_pitch_deg <= pitch;
            i_roll_deg  <= roll;
            i_yaw_deg   <= yaw;
            do @(posedge i_clk); while (o_stall);
            matrix_queue.push_back(rotation_matrix(pitch, roll, yaw));
            n_sent++;
        end
    endtask

    // wait until every prediction has been matched
    task automatic wait_drained();
        begin
            i_valid <= 1'b0;
            while (matrix_queue.size() != 0) @(posedge i_clk);
        end
    endtask

    // random angle: mostly within +-180, sometimes anything the field holds
    function automatic logic [15:0] rand_angle();
        int sel;
        begin
            sel = $urandom_range(9);
            if (sel < 6) return 16'($signed($urandom_range(2 * 180 * ONE_DEG)) - 180 * ONE_DEG);
            if (sel < 8) return 16'($urandom);
            // multiples of 45 degrees plus or minus one lsb hit the fold edges
            return 16'(($signed($urandom_range(8)) - 4) * 45 * ONE_DEG
                       + $signed($urandom_range(2)) - 1);
        end
    endfunction

    // field extremes, clamp limits, fold boundaries and the identity case
    task automatic test_directed();
        logic signed [15:0] pts[12];
        begin
            pts = '{16'sd0, 16'sd32767, -16'sd32768, 16'(180 * ONE_DEG),
                    16'(-180 * ONE_DEG), 16'(180 * ONE_DEG + 1), 16'(90 * ONE_DEG),
                    16'(-90 * ONE_DEG), 16'(45 * ONE_DEG), 16'(45 * ONE_DEG + 1),
                    16'(135 * ONE_DEG), 16'sd1};
            send_angles(0, 0, 0);                     // identity
            for (int k = 1; k < 12; k++) begin
                send_angles(pts[k], 0, 0);
                send_angles(0, pts[k], 0);
            end
            send_angles(0, 0, 16'sd32767);
            send_angles(0, 0, -16'sd32768);
            send_angles(16'(30 * ONE_DEG), 16'(-60 * ONE_DEG), 16'(135 * ONE_DEG));
        end
    endtask

    // random triples, one long stretch with no idling
    task automatic test_random();
        begin
            for (int k = 0; k < N_RANDOM; k++) begin
                calm = (k >= 200 && k < 300);
                send_angles(rand_angle(), rand_angle(), rand_angle());
            end
            calm = 0;
        end
    endtask

    // result side held off long enough that the pipeline fills and stalls
    task automatic test_backpressure();
        begin
            hold_cycles <= 120;
            for (int k = 0; k < 40; k++) send_angles(rand_angle(), rand_angle(), rand_angle());
        end
    endtask

    // sender pauses until everything has come out, then resumes
    task automatic test_drain_pause();
        begin
            wait_drained();
            for (int k = 0; k < 10; k++) send_angles(rand_angle(), rand_angle(), rand_angle());
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_stall     <= 1'b0;
        i_pitch_deg <= '0;
        i_roll_deg  <= '0;
        i_yaw_deg   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random();

        wait_drained();
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("covered %0d angle triples: extremes, clamping, fold edges, identity,",
                 n_sent);
        $display("random poses, a long result hold-off and a full drain; %0d checked",
                 n_checked);
        if (n_errors == 0 && matrix_queue.size() == 0) begin
            $display("euler_to_rotation_matrix_core regression: pass");
        end else begin
            $display("euler_to_rotation_matrix_core regression: fail");
        end
        $finish;
    end

endmodule

[euler_to_rotation_matrix_core.f]
design/e2r_pkg.sv
design/e2r_sincos.sv
design/e2r_matrix.sv
design/euler_to_rotation_matrix_core.sv
tb/tb.sv
